// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define PAL_ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on the house clock and reset names.
`define PAL_ASSERT(lbl, prop, msg) `PAL_ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== hdl/pal_pkg.sv =====
// Package: field widths, codes and controller/datapath handshake types.
package pal_pkg;

  localparam int unsigned MODE_W    = 2;
  localparam int unsigned POS_W     = 7;
  localparam int unsigned ELEM_W    = 32;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned CNT_OUT_W = 7;

  localparam logic [MODE_W-1:0] MODE_READ   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  typedef struct packed {
    logic capture;  // latch request beat
    logic check;    // classify request, start read or shift
    logic step;     // one shift step
    logic finish;   // commit and load result
  } pal_cmd_t;

  typedef struct packed {
    logic shift_req;   // request needs the shift loop
    logic shift_done;  // shift loop drained
    logic out_free;    // result register can take a beat
  } pal_sts_t;

endpackage

// ===== hdl/pal_if.sv =====
// Request and response channel interfaces.
interface pal_req_if import pal_pkg::*;;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [POS_W-1:0]  position;
  logic [ELEM_W-1:0] element;

  modport source (output valid, output mode, output position, output element, input ready);
  modport sink (input valid, input mode, input position, input element, output ready);
endinterface

interface pal_rsp_if import pal_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [STAT_W-1:0]    status;
  logic [ELEM_W-1:0]    read_data;
  logic [CNT_OUT_W-1:0] count;

  modport source (output valid, output status, output read_data, output count, input ready);
  modport sink (input valid, input status, input read_data, input count, output ready);
endinterface

// ===== hdl/pal_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pal_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/pal_ctrl.sv =====
// Controller: sequences capture, check, shift loop and result load.
module pal_ctrl import pal_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  input  pal_sts_t sts_i,
  output pal_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SHIFT,
    S_FINISH
  } state_e;

  state_e state_q;
  logic   in_ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      in_ready_q <= 1'b1;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (req_valid_i && in_ready_q) begin
            state_q    <= S_CHECK;
            in_ready_q <= 1'b0;
          end
        end
        S_CHECK: begin
          state_q <= sts_i.shift_req ? S_SHIFT : S_FINISH;
        end
        S_SHIFT: begin
          if (sts_i.shift_done) begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (sts_i.out_free) begin
            state_q    <= S_IDLE;
            in_ready_q <= 1'b1;
          end
        end
        default: begin
          state_q    <= S_IDLE;
          in_ready_q <= 1'b1;
        end
      endcase
    end
  end

  assign req_ready_o    = in_ready_q;
  assign cmd_o.capture  = (state_q == S_IDLE) && req_valid_i && in_ready_q;
  assign cmd_o.check    = (state_q == S_CHECK);
  assign cmd_o.step     = (state_q == S_SHIFT);
  assign cmd_o.finish   = (state_q == S_FINISH) && sts_i.out_free;

endmodule

// ===== hdl/pal_dp.sv =====
// Datapath: request registers, entry store, shift walker, count and result register.
module pal_dp import pal_pkg::*; #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pal_cmd_t             cmd_i,
  output pal_sts_t             sts_o,
  input  logic [MODE_W-1:0]    mode_i,
  input  logic [POS_W-1:0]     position_i,
  input  logic [ELEM_W-1:0]    element_i,
  input  logic                 rsp_ready_i,
  output logic                 rsp_valid_o,
  output logic [STAT_W-1:0]    status_o,
  output logic [ELEM_W-1:0]    read_data_o,
  output logic [CNT_OUT_W-1:0] count_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = ((CW > POS_W) ? CW : POS_W) + 1;

  // request
  logic [MODE_W-1:0] mode_q;
  logic [POS_W-1:0]  pos_q;
  logic [ELEM_W-1:0] elem_q;
  status_e           status_q;

  // list state and shift walker
  logic [CW-1:0] count_q, count_d;
  logic [XW-1:0] idx_q;
  logic          wr_pend_q;
  logic [AW-1:0] wr_addr_q;

  // result
  logic                 rsp_valid_q;
  status_e              rsp_status_q;
  logic [ELEM_W-1:0]    rsp_data_q;
  logic [CNT_OUT_W-1:0] rsp_count_q;

  logic [XW-1:0] pos_x, cnt_x, cap_x, pos_m1, idx_m1, idx_p1;
  status_e       status_c;
  logic          is_ins, is_rem, is_rd, more, out_free;

  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata, elem_st;
  logic [ELEM_W-1:0]     rd_ext;

  assign pos_x  = XW'(pos_q);
  assign cnt_x  = XW'(count_q);
  assign cap_x  = XW'(CAPACITY);
  assign pos_m1 = pos_x - XW'(1);
  assign idx_m1 = idx_q - XW'(1);
  assign idx_p1 = idx_q + XW'(1);

  assign is_rd  = (mode_q == MODE_READ);
  assign is_ins = (mode_q == MODE_INSERT);
  assign is_rem = (mode_q == MODE_REMOVE);

  always_comb begin
    status_c = ST_BADPOS;
    case (mode_q)
      MODE_READ, MODE_REMOVE: begin
        if (count_q == '0) begin
          status_c = ST_EMPTY;
        end else if ((pos_q != '0) && (pos_x <= cnt_x)) begin
          status_c = ST_OK;
        end
      end
      MODE_INSERT: begin
        if (cnt_x >= cap_x) begin
          status_c = ST_FULL;
        end else if ((pos_q != '0) && (pos_x <= cnt_x + XW'(1))) begin
          status_c = ST_OK;
        end
      end
      default: status_c = ST_BADPOS;
    endcase
  end

  // insert walks down from count to pos, remove walks up from pos to count-1
  assign more = is_ins ? (idx_q >= pos_x) : (idx_q < cnt_x);

  assign elem_st = DATA_WIDTH'(elem_q);
  assign rd_ext  = ELEM_W'(ram_rdata);

  assign ram_re    = (cmd_i.check && (status_c == ST_OK) && is_rd) || (cmd_i.step && more);
  assign ram_raddr = cmd_i.check ? pos_m1[AW-1:0] : (is_ins ? idx_m1[AW-1:0] : idx_q[AW-1:0]);
  assign ram_we    = wr_pend_q || (cmd_i.finish && (status_q == ST_OK) && is_ins);
  assign ram_waddr = wr_pend_q ? wr_addr_q : pos_m1[AW-1:0];
  assign ram_wdata = wr_pend_q ? ram_rdata : elem_st;

  pal_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (ram_we),
    .wr_addr_i(ram_waddr),
    .wr_data_i(ram_wdata),
    .rd_en_i  (ram_re),
    .rd_addr_i(ram_raddr),
    .rd_data_o(ram_rdata)
  );

  always_comb begin
    count_d = count_q;
    if (cmd_i.finish && (status_q == ST_OK)) begin
      if (is_ins) begin
        count_d = count_q + CW'(1);
      end else if (is_rem) begin
        count_d = count_q - CW'(1);
      end
    end
  end

  assign out_free = !rsp_valid_q || rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      wr_pend_q   <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.step) begin
        wr_pend_q <= more;
      end
      if (cmd_i.finish) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= mode_i;
      pos_q  <= position_i;
      elem_q <= element_i;
    end
    if (cmd_i.check) begin
      status_q <= status_c;
      idx_q    <= is_ins ? cnt_x : pos_x;
    end
    if (cmd_i.step && more) begin
      wr_addr_q <= is_ins ? idx_q[AW-1:0] : idx_m1[AW-1:0];
      idx_q     <= is_ins ? idx_m1 : idx_p1;
    end
    if (cmd_i.finish) begin
      rsp_status_q <= status_q;
      rsp_data_q   <= ((status_q == ST_OK) && is_rd) ? rd_ext : '0;
      rsp_count_q  <= CNT_OUT_W'(count_d);
    end
  end

  assign sts_o.shift_req  = (status_c == ST_OK) && (is_ins || is_rem);
  assign sts_o.shift_done = !more && !wr_pend_q;
  assign sts_o.out_free   = out_free;

  assign rsp_valid_o = rsp_valid_q;
  assign status_o    = rsp_status_q;
  assign read_data_o = rsp_data_q;
  assign count_o     = rsp_count_q;

endmodule

// ===== hdl/positional_array_list.sv =====
// A read or rejected request goes from the request beat through check to finish,
// where the result is loaded once the result register is free. Insert/remove
// moving n entries adds a shift loop; n is at most CAPACITY - 1, one entry per
// cycle through the single read and single write port. No new request beat is
// taken until the cycle after the result is loaded, even if the result still waits.
// Reset (async, active low) empties the list; stored entries are not cleared.
module positional_array_list import pal_pkg::*; #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  pal_req_if.sink  req,
  pal_rsp_if.source rsp
);

  // Controller and datapath talk only through these two bundles.
  pal_cmd_t cmd;
  pal_sts_t sts;
  logic     req_ready;

  // Controller: idle -> check -> (shift) -> finish. Only takes a request beat in idle.
  pal_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req.valid),
    .req_ready_o(req_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  assign req.ready = req_ready;

  // Datapath: entry store in RAM, shift walker overlaps read of one entry with the
  // write of the one before; result register decouples the response side.
  pal_dp #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .mode_i     (req.mode),
    .position_i (req.position),
    .element_i  (req.element),
    .rsp_ready_i(rsp.ready),
    .rsp_valid_o(rsp.valid),
    .status_o   (rsp.status),
    .read_data_o(rsp.read_data),
    .count_o    (rsp.count)
  );

endmodule

// ===== hdl/pal_checker.sv =====
// Port-level checker for the positional list, bound to the top level.
`include "assert_macros.svh"

module pal_checker import pal_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 req_valid_i,
  input logic                 req_ready_i,
  input logic                 rsp_valid_i,
  input logic                 rsp_ready_i,
  input logic [STAT_W-1:0]    rsp_status_i,
  input logic [ELEM_W-1:0]    rsp_read_data_i,
  input logic [CNT_OUT_W-1:0] rsp_count_i
);

  localparam logic [CNT_OUT_W-1:0] CAP_LO = CNT_OUT_W'(CAPACITY);

  // requests taken but not yet answered
  logic [1:0] outst_q;
  logic       req_beat, rsp_beat;

  assign req_beat = req_valid_i && req_ready_i;
  assign rsp_beat = rsp_valid_i && rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outst_q <= '0;
    end else if (req_beat && !rsp_beat) begin
      outst_q <= outst_q + 2'd1;
    end else if (rsp_beat && !req_beat) begin
      outst_q <= outst_q - 2'd1;
    end
  end

  `PAL_ASSERT(a_rsp_has_req, rsp_valid_i |-> (outst_q != 2'd0), "result without request")
  `PAL_ASSERT(a_outst_bound, outst_q != 2'd3, "too many requests in flight")
  `PAL_ASSERT(a_empty_count, (rsp_valid_i && (rsp_status_i == ST_EMPTY)) |-> (rsp_count_i == '0), "empty status with nonzero count")
  `PAL_ASSERT(a_full_count, (rsp_valid_i && (rsp_status_i == ST_FULL)) |-> (rsp_count_i == CAP_LO), "full status below capacity")
  `PAL_ASSERT(a_rsp_hold, (rsp_valid_i && !rsp_ready_i) |=> (rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_read_data_i) && $stable(rsp_count_i)), "stalled result changed")

endmodule

bind positional_array_list pal_checker #(
  .CAPACITY(CAPACITY)
) u_pal_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req.valid),
  .req_ready_i    (req.ready),
  .rsp_valid_i    (rsp.valid),
  .rsp_ready_i    (rsp.ready),
  .rsp_status_i   (rsp.status),
  .rsp_read_data_i(rsp.read_data),
  .rsp_count_i    (rsp.count)
);

// ===== sim/positional_array_list_test.sv =====
// Self-checking testbench for the positional list block: random traffic, gaps and stalls.
`timescale 1ns / 1ps

module positional_array_list_test;
  import pal_pkg::*;

  localparam int unsigned CAPACITY = 64;
  // Mode value three is not a real operation; the block must answer bad position.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 1000;
  localparam int unsigned DRAIN_CYCLES = 100;  // longest shift plus result slack

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  position;
    logic [ELEM_W-1:0] element;
  } list_req_t;

  typedef struct packed {
    status_e              status;
    logic [ELEM_W-1:0]    read_data;
    logic [CNT_OUT_W-1:0] count;
  } list_rsp_t;

  // Request waiting in the driver queue. hold makes the driver wait until
  // every outstanding result has come back; quiet turns off idling on both sides.
  typedef struct {
    list_req_t rq;
    bit        hold;
    bit        quiet;
  } pending_req_t;

  typedef struct {
    logic [ELEM_W-1:0] slot [CAPACITY];
    int unsigned       len;
  } list_state_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  pal_req_if req_bus ();
  pal_rsp_if rsp_bus ();

  positional_array_list u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_bus),
    .rsp    (rsp_bus)
  );

  // Two copies of the list: one advanced while building stimulus, so that
  // sequences can target valid positions, and one advanced on accepted beats.
  list_state_t  gen_list;
  list_state_t  dut_list;
  pending_req_t pending_reqs[$];
  list_rsp_t    expected_rsps[$];

  bit gen_quiet;
  bit quiet_now;
  int unsigned gen_total;
  int unsigned send_gap;
  int unsigned stall_left;
  logic req_taken;
  logic rsp_taken;

  int unsigned err_count;
  int unsigned req_beats;
  int unsigned rsp_beats;
  int unsigned peak_len;
  int unsigned status_seen [4];

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Behavior of one request on a list: shifts, bounds and status priority.
  // Empty is checked before position on read and remove, full before position
  // on insert; position zero and unused mode fall through to bad position.
  function automatic list_rsp_t list_apply(inout list_state_t st, input list_req_t rq);
    list_rsp_t r;
    int        p;
    r.status    = ST_BADPOS;
    r.read_data = '0;
    p           = int'(rq.position);
    case (rq.mode)
      MODE_READ: begin
        if (st.len == 0) begin
          r.status = ST_EMPTY;
        end else if (p >= 1 && p <= int'(st.len)) begin
          r.status    = ST_OK;
          r.read_data = st.slot[p-1];
        end
      end
      MODE_INSERT: begin
        if (st.len >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (p >= 1 && p <= int'(st.len) + 1) begin
          for (int i = int'(st.len); i >= p; i--) st.slot[i] = st.slot[i-1];
          st.slot[p-1] = rq.element;
          st.len++;
          r.status = ST_OK;
        end
      end
      MODE_REMOVE: begin
        if (st.len == 0) begin
          r.status = ST_EMPTY;
        end else if (p >= 1 && p <= int'(st.len)) begin
          for (int i = p; i < int'(st.len); i++) st.slot[i-1] = st.slot[i];
          st.len--;
          r.status = ST_OK;
        end
      end
      default: ;
    endcase
    r.count = CNT_OUT_W'(st.len);
    return r;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int unsigned idle_gap(bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [ELEM_W-1:0] rand_handle();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // Position in 1..len+extra most of the time, else just past the end,
  // zero, or anywhere in the field.
  function automatic int unsigned pick_pos(int unsigned len, int unsigned extra);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85 && len + extra > 0) return $urandom_range(1, len + extra);
    if (r < 92) return len + extra + 1;
    if (r < 96) return 0;
    return $urandom_range(0, 127);
  endfunction

  task automatic queue_req(input logic [MODE_W-1:0] m, input int unsigned p,
                           input logic [ELEM_W-1:0] e, input bit hold = 1'b0);
    pending_req_t pr;
    pr.rq.mode     = m;
    pr.rq.position = POS_W'(p);
    pr.rq.element  = e;
    pr.hold        = hold || ($urandom_range(0, 199) == 0);
    pr.quiet       = gen_quiet;
    void'(list_apply(gen_list, pr.rq));
    pending_reqs.push_back(pr);
    gen_total++;
  endtask

  // Well-formed traffic: mostly valid positions, random handles.
  task automatic mixed_run(input int unsigned n);
    int unsigned kind;
    for (int k = 0; k < n; k++) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) queue_req(MODE_READ, pick_pos(gen_list.len, 0), rand_handle());
      else if (kind < 70) queue_req(MODE_INSERT, pick_pos(gen_list.len, 1), rand_handle());
      else if (kind < 97) queue_req(MODE_REMOVE, pick_pos(gen_list.len, 0), rand_handle());
      else queue_req(MODE_UNUSED, $urandom_range(0, 127), rand_handle());
    end
  endtask

  // Grow to capacity, then hit the full list from every angle.
  task automatic fill_run();
    while (gen_list.len < CAPACITY)
      queue_req(MODE_INSERT, $urandom_range(1, gen_list.len + 1), rand_handle());
    queue_req(MODE_INSERT, 0, rand_handle());
    queue_req(MODE_INSERT, CAPACITY + 1, rand_handle());
    queue_req(MODE_INSERT, $urandom_range(1, CAPACITY), rand_handle());
    queue_req(MODE_INSERT, 127, rand_handle());
    queue_req(MODE_READ, CAPACITY, rand_handle());
    queue_req(MODE_READ, CAPACITY + 1, rand_handle());
    queue_req(MODE_READ, 1, rand_handle());
    queue_req(MODE_UNUSED, CAPACITY, rand_handle());
  endtask

  // Shrink to nothing, then poke the empty list.
  task automatic drain_run();
    while (gen_list.len > 0)
      queue_req(MODE_REMOVE, $urandom_range(1, gen_list.len), rand_handle());
    queue_req(MODE_REMOVE, 0, rand_handle());
    queue_req(MODE_REMOVE, 1, rand_handle());
    queue_req(MODE_READ, 1, rand_handle());
    queue_req(MODE_READ, 0, rand_handle());
    queue_req(MODE_INSERT, 2, rand_handle());
  endtask

  task automatic noise_run(input int unsigned n);
    for (int k = 0; k < n; k++)
      queue_req(MODE_W'($urandom_range(0, 3)), $urandom_range(0, 127), $urandom);
  endtask

  // Driver: inputs change on the falling edge only.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
    end else if (!(req_bus.valid && !req_taken)) begin
      // Previous beat went through (or nothing was up): idle or present the next one.
      if (send_gap > 0) begin
        req_bus.valid <= 1'b0;
        send_gap      <= send_gap - 1;
      end else if (pending_reqs.size() > 0 &&
                   !(pending_reqs[0].hold && expected_rsps.size() > 0)) begin
        pending_req_t pr;
        pr = pending_reqs.pop_front();
        req_bus.valid    <= 1'b1;
        req_bus.mode     <= pr.rq.mode;
        req_bus.position <= pr.rq.position;
        req_bus.element  <= pr.rq.element;
        quiet_now        <= pr.quiet;
        send_gap         <= idle_gap(pr.quiet);
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure: after a beat, maybe hold ready low for a while.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
    end else if (stall_left > 0) begin
      rsp_bus.ready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (rsp_taken) begin
      int unsigned g;
      g = idle_gap(quiet_now);
      rsp_bus.ready <= (g == 0);
      stall_left    <= (g == 0) ? 0 : g - 1;
    end else begin
      rsp_bus.ready <= 1'b1;
    end
  end

  // Monitor: sample both channels on the rising edge, predict on request
  // beats, check on result beats.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_taken <= 1'b0;
      rsp_taken <= 1'b0;
    end else begin
      req_taken <= req_bus.valid && req_bus.ready;
      rsp_taken <= rsp_bus.valid && rsp_bus.ready;
      if (req_bus.valid && req_bus.ready) begin
        list_req_t rq;
        rq.mode     = req_bus.mode;
        rq.position = req_bus.position;
        rq.element  = req_bus.element;
        expected_rsps.push_back(list_apply(dut_list, rq));
        if (dut_list.len > peak_len) peak_len = dut_list.len;
        req_beats++;
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        list_rsp_t want;
        rsp_beats++;
        if (expected_rsps.size() == 0) begin
          $error("result beat with no request outstanding: status %0d data %h count %0d",
                 rsp_bus.status, rsp_bus.read_data, rsp_bus.count);
          err_count++;
        end else begin
          want = expected_rsps.pop_front();
          status_seen[want.status]++;
          if (rsp_bus.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_bus.status);
            err_count++;
          end
          if (rsp_bus.read_data !== want.read_data) begin
            $error("read_data: expected %h, actual %h", want.read_data, rsp_bus.read_data);
            err_count++;
          end
          if (rsp_bus.count !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, rsp_bus.count);
            err_count++;
          end
        end
      end
    end
  end

  initial begin
    int unsigned pick;
    req_bus.valid    = 1'b0;
    req_bus.mode     = MODE_READ;
    req_bus.position = '0;
    req_bus.element  = '0;
    rsp_bus.ready    = 1'b0;
    req_taken        = 1'b0;
    rsp_taken        = 1'b0;
    send_gap         = 0;
    stall_left       = 0;
    quiet_now        = 1'b0;
    gen_quiet        = 1'b0;
    gen_list.len     = 0;
    dut_list.len     = 0;

    // Directed: empty list, bounds on every operation, front/middle/end shifts.
    queue_req(MODE_READ, 1, '0);
    queue_req(MODE_READ, 0, '1);
    queue_req(MODE_REMOVE, 0, '0);
    queue_req(MODE_REMOVE, 127, '0);
    queue_req(MODE_INSERT, 0, 32'h1234_5678);
    queue_req(MODE_INSERT, 2, 32'h1234_5678);
    queue_req(MODE_INSERT, 1, 32'hFFFF_FFFF);
    queue_req(MODE_INSERT, 1, 32'h0000_0000);
    queue_req(MODE_INSERT, 3, 32'hA5A5_A5A5);
    queue_req(MODE_INSERT, 2, 32'h5A5A_5A5A);
    for (int p = 1; p <= 4; p++) queue_req(MODE_READ, p, '0);
    queue_req(MODE_READ, 0, '0);
    queue_req(MODE_READ, 5, '0);
    queue_req(MODE_READ, 127, '0);
    queue_req(MODE_UNUSED, 1, '1);
    queue_req(MODE_INSERT, 6, '1);
    queue_req(MODE_INSERT, 127, '1);
    queue_req(MODE_REMOVE, 5, '0);
    queue_req(MODE_REMOVE, 0, '0);
    // Let everything drain before this one goes out.
    queue_req(MODE_REMOVE, 2, '0, 1'b1);
    queue_req(MODE_REMOVE, 3, '0);
    queue_req(MODE_REMOVE, 1, '0);
    queue_req(MODE_READ, 1, '0);

    // Random part: always one trip to full first, then a mix of segments.
    gen_total = 0;
    fill_run();
    while (gen_total < RANDOM_ITEMS) begin
      gen_quiet = ($urandom_range(0, 3) == 0);
      pick      = $urandom_range(0, 99);
      if (pick < 45) mixed_run($urandom_range(15, 40));
      else if (pick < 60) fill_run();
      else if (pick < 75) drain_run();
      else noise_run($urandom_range(4, 12));
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || req_bus.valid || expected_rsps.size() != 0)
      @(posedge clk_i);
    // Anything arriving now would be a stray result.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_rsps.size() != 0) begin
      $error("%0d results never arrived", expected_rsps.size());
      err_count++;
    end

    $display("Summary: %0d requests, %0d results; list depth peaked at %0d of %0d",
             req_beats, rsp_beats, peak_len, CAPACITY);
    $display("Summary: ok %0d, empty %0d, full %0d, bad position %0d; %0d mismatches",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_FULL],
             status_seen[ST_BADPOS], err_count);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
